[rtl/range_coalesce_discard_split_defines.svh]
// Assertion macros shared by the range coalescer RTL.
`ifndef RANGE_COALESCE_DISCARD_SPLIT_DEFINES_SVH
`define RANGE_COALESCE_DISCARD_SPLIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RCDS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RCDS_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define RCDS_CHECK(lbl, prop, msg)
`define RCDS_CHECK_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/rcds_pkg.sv]
// Shared codes and constants for the range coalescer.
package rcds_pkg;

  localparam int CMD_W      = 2;
  localparam int ACT_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;
  localparam int BSL_W      = 5;

  localparam logic [BSL_W-1:0] BSL_MIN   = 5'd9;
  localparam logic [BSL_W-1:0] BSL_MAX   = 5'd17;
  localparam logic [BSL_W-1:0] BSL_RESET = 5'd12;

  // result slots per item, in emit order
  localparam int NSLOT       = 4;
  localparam int SLOT_IW     = $clog2(NSLOT);
  localparam int SLOT_COPY   = 0;
  localparam int SLOT_MAIN   = 1;
  localparam int SLOT_HEAD   = 2;
  localparam int SLOT_TAIL   = 3;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_COPY    = 2'd0,
    ACT_DISCARD = 2'd1,
    ACT_ZERO    = 2'd2
  } act_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_SIZE_LOG2 = 2'd0,
    CFG_VOLUME_SIZE     = 2'd1
  } cfg_idx_t;

endpackage

[rtl/rcds_front.sv]
// Front end: pending-range tracking, free clamping and split into result slots.
`include "range_coalesce_discard_split_defines.svh"
module rcds_front #(
  parameter int ADDR_BITS = 48
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic [ADDR_BITS+1:0]                                blk_mask,
  input  logic [ADDR_BITS-1:0]                                vol,
  input  logic                                                in_valid,
  output logic                                                in_ready,
  input  logic [rcds_pkg::CMD_W-1:0]                          command,
  input  logic [ADDR_BITS-1:0]                                offset,
  input  logic signed [ADDR_BITS-1:0]                         length,
  output logic                                                job_push,
  input  logic                                                job_ready,
  output logic [rcds_pkg::NSLOT-1:0]                          job_valid,
  output logic [rcds_pkg::NSLOT-1:0][rcds_pkg::ACT_W-1:0]     job_action,
  output logic [rcds_pkg::NSLOT-1:0][ADDR_BITS:0]             job_start,
  output logic [rcds_pkg::NSLOT-1:0][ADDR_BITS:0]             job_size
);
  import rcds_pkg::*;

  localparam int W = ADDR_BITS + 1;
  localparam int X = ADDR_BITS + 2;

  logic                 in_fire;
  logic                 en;
  logic                 pend_valid;
  logic [W-1:0]         pend_start;
  logic [W-1:0]         pend_end;
  logic                 neg;
  logic [ADDR_BITS-1:0] wlen;
  logic [W-1:0]         wend;
  logic                 hit;
  logic                 send;
  logic                 copy_v;

  logic                 a_valid;
  logic                 a_copy_v;
  logic [W-1:0]         a_copy_start;
  logic [W-1:0]         a_copy_size;
  logic                 a_free;
  logic [ADDR_BITS-1:0] a_offset;
  logic [ADDR_BITS-1:0] a_len;
  logic                 a_neg;
  logic [W-1:0]         a_sum;
  logic                 a_over;
  logic                 a_drop;
  logic [W-1:0]         a_end;
  logic [X-1:0]         a_al;

  logic                 b_valid;
  logic                 b_copy_v;
  logic [W-1:0]         b_copy_start;
  logic [W-1:0]         b_copy_size;
  logic                 b_free;
  logic [ADDR_BITS-1:0] b_offset;
  logic [W-1:0]         b_end;
  logic [X-1:0]         b_al;
  logic [X-1:0]         b_bl;
  logic [X-1:0]         b_off;
  logic [X-1:0]         b_endx;
  logic                 b_lt;

  assign job_push = b_valid && (|job_valid);
  assign en       = !job_push || job_ready;
  assign in_ready = en;
  assign in_fire  = in_valid && in_ready;

  // accept side: coalesce writes, decide whether the pending copy goes out
  assign neg  = length[ADDR_BITS-1];
  assign wlen = neg ? '0 : $unsigned(length);
  assign wend = W'(offset) + W'(wlen);
  assign hit  = pend_valid && (pend_end == W'(offset));

  always_comb begin
    case (command)
      CMD_WRITE: send = !hit;
      CMD_FREE:  send = 1'b1;
      CMD_FLUSH: send = 1'b1;
      default:   send = 1'b0;
    endcase
  end

  assign copy_v = send && pend_valid && (pend_end > pend_start);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      pend_start <= '0;
      pend_end   <= '0;
    end else if (in_fire) begin
      case (command)
        CMD_WRITE: begin
          pend_valid <= 1'b1;
          pend_end   <= wend;
          if (!hit) begin
            pend_start <= W'(offset);
          end
        end
        CMD_FREE:  pend_valid <= 1'b0;
        CMD_FLUSH: pend_valid <= 1'b0;
        default:   pend_valid <= pend_valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid      <= in_fire;
      a_copy_v     <= in_fire && copy_v;
      a_copy_start <= pend_start;
      a_copy_size  <= pend_end - pend_start;
      a_free       <= in_fire && (command == CMD_FREE);
      a_offset     <= offset;
      a_len        <= $unsigned(length);
      a_neg        <= neg;
    end
  end

  // clamp to volume end, round start up to a block
  assign a_sum  = W'(a_offset) + W'(a_len);
  assign a_over = a_neg || (a_sum > W'(vol));
  assign a_drop = a_over ? (a_offset >= vol) : (a_len == '0);
  assign a_end  = a_over ? W'(vol) : a_sum;
  assign a_al   = (X'(a_offset) + blk_mask) & ~blk_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid      <= a_valid;
      b_copy_v     <= a_valid && a_copy_v;
      b_copy_start <= a_copy_start;
      b_copy_size  <= a_copy_size;
      b_free       <= a_valid && a_free && !a_drop;
      b_offset     <= a_offset;
      b_end        <= a_end;
      b_al         <= a_al;
    end
  end

  // split into discard plus head and tail zero-fills, or a single zero-fill if no whole block fits
  assign b_endx = X'(b_end);
  assign b_off  = X'(b_offset);
  assign b_bl   = b_endx & ~blk_mask;
  assign b_lt   = b_al < b_bl;

  always_comb begin
    job_valid[SLOT_COPY]  = b_copy_v;
    job_action[SLOT_COPY] = ACT_COPY;
    job_start[SLOT_COPY]  = b_copy_start;
    job_size[SLOT_COPY]   = b_copy_size;

    job_valid[SLOT_MAIN] = b_free;
    if (b_lt) begin
      job_action[SLOT_MAIN] = ACT_DISCARD;
      job_start[SLOT_MAIN]  = W'(b_al);
      job_size[SLOT_MAIN]   = W'(b_bl - b_al);
    end else begin
      job_action[SLOT_MAIN] = ACT_ZERO;
      job_start[SLOT_MAIN]  = W'(b_offset);
      job_size[SLOT_MAIN]   = b_end - W'(b_offset);
    end

    job_valid[SLOT_HEAD]  = b_free && b_lt && (b_al > b_off);
    job_action[SLOT_HEAD] = ACT_ZERO;
    job_start[SLOT_HEAD]  = W'(b_offset);
    job_size[SLOT_HEAD]   = W'(b_al - b_off);

    job_valid[SLOT_TAIL]  = b_free && b_lt && (b_endx > b_bl);
    job_action[SLOT_TAIL] = ACT_ZERO;
    job_start[SLOT_TAIL]  = W'(b_bl);
    job_size[SLOT_TAIL]   = W'(b_endx - b_bl);
  end

  `RCDS_CHECK(a_free_nonempty, b_valid && b_free |-> (W'(b_offset) < b_end), "empty free kept")
  `RCDS_CHECK_NEXT(a_write_opens, in_fire && (command == CMD_WRITE), pend_valid, "no pending range")

endmodule

[rtl/rcds_queue.sv]
// Small register FIFO between front and back end.
`include "range_coalesce_discard_split_defines.svh"
module rcds_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             ready,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             wr_en;

  assign ready = count != CW'(DEPTH);
  assign valid = count != '0;
  assign dout  = mem[rd_ptr];
  assign wr_en = wr_valid && ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (wr_en && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !wr_en) begin
        count <= count - CW'(1);
      end
    end
  end

  `RCDS_CHECK(a_q_count_range, count <= CW'(DEPTH), "queue count out of range")
  `RCDS_CHECK(a_q_no_underflow, pop |-> valid, "pop from empty queue")
  `RCDS_CHECK(a_q_ptr_match, (count == '0) |-> (wr_ptr == rd_ptr), "queue pointers out of step")

endmodule

[rtl/rcds_back.sv]
// Back end: walks the slots of the head entry, one result per cycle while out_ready is high.
`include "range_coalesce_discard_split_defines.svh"
module rcds_back #(
  parameter int ADDR_BITS = 48
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            q_valid,
  output logic                                            q_pop,
  input  logic [rcds_pkg::NSLOT-1:0]                      head_valid,
  input  logic [rcds_pkg::NSLOT-1:0][rcds_pkg::ACT_W-1:0] head_action,
  input  logic [rcds_pkg::NSLOT-1:0][ADDR_BITS:0]         head_start,
  input  logic [rcds_pkg::NSLOT-1:0][ADDR_BITS:0]         head_size,
  output logic                                            out_valid,
  input  logic                                            out_ready,
  output logic [rcds_pkg::ACT_W-1:0]                      action,
  output logic [ADDR_BITS:0]                              start_res,
  output logic [ADDR_BITS:0]                              size,
  output logic                                            last
);
  import rcds_pkg::*;

  logic [NSLOT-1:0]   done;
  logic [NSLOT-1:0]   rem;
  logic [NSLOT-1:0]   sel;
  logic [SLOT_IW-1:0] idx;
  logic               load;
  logic               fin;

  always_comb begin
    rem = head_valid & ~done;
    idx = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (rem[i]) begin
        idx = SLOT_IW'(i);
      end
    end
    sel = (|rem) ? (NSLOT'(1) << idx) : '0;
  end

  assign fin   = (rem & ~sel) == '0;
  assign load  = q_valid && (!out_valid || out_ready);
  assign q_pop = load && fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done      <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      action    <= head_action[idx];
      start_res <= head_start[idx];
      size      <= head_size[idx];
      last      <= fin;
      done      <= fin ? '0 : (done | sel);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `RCDS_CHECK(a_back_slot_left, load |-> (rem != '0), "queued entry with no result left")

endmodule

[rtl/range_coalesce_discard_split.sv]
// Top level of the changed-range coalescer with discard and zero-fill split.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one record per item: command, offset, length.
//   Output channel (out_valid/out_ready) gives one device command per item: action,
//   start_res, size, last; last marks the final command caused by an input record.
//   Config channel (cfg_valid/cfg_ready) writes block_size_log2 (index 0) and
//   volume_size (index 1); cfg_ready is always high, write only while idle.
// Timing:
//   A record is accepted every cycle while in_ready is high. Its first command
//   passes front stage one, which loads at the accepting edge, then front stage
//   two, the queue and the output register. Commands leave at one per cycle while
//   out_ready is high; a record makes 0 to 4, so the output port is the rate limit.
// Reset:
//   Clears the pending range and the queue; block_size_log2 returns to 12 and
//   volume_size to 0. No clearing pass, the block is ready right after reset.
// Stall:
//   With out_ready low the output register holds, the 2-entry queue fills and
//   in_ready drops until room frees up.
module range_coalesce_discard_split #(
  parameter int ADDR_BITS = 48
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rcds_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rcds_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [rcds_pkg::CMD_W-1:0]           command,
  input  logic [ADDR_BITS-1:0]                 offset,
  input  logic signed [ADDR_BITS-1:0]          length,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [rcds_pkg::ACT_W-1:0]           action,
  output logic [ADDR_BITS:0]                   start_res,
  output logic [ADDR_BITS:0]                   size,
  output logic                                 last
);
  import rcds_pkg::*;

  localparam int W  = ADDR_BITS + 1;
  localparam int X  = ADDR_BITS + 2;
  localparam int QW = NSLOT * (1 + ACT_W + 2 * W);

  logic [X-1:0]                  blk_mask;
  logic [ADDR_BITS-1:0]          vol;
  logic [BSL_W-1:0]              sh_sat;

  logic                          job_push;
  logic                          job_ready;
  logic [NSLOT-1:0]              job_valid;
  logic [NSLOT-1:0][ACT_W-1:0]   job_action;
  logic [NSLOT-1:0][W-1:0]       job_start;
  logic [NSLOT-1:0][W-1:0]       job_size;

  logic                          q_valid;
  logic                          q_pop;
  logic [QW-1:0]                 q_din;
  logic [QW-1:0]                 q_dout;
  logic [NSLOT-1:0]              head_valid;
  logic [NSLOT-1:0][ACT_W-1:0]   head_action;
  logic [NSLOT-1:0][W-1:0]       head_start;
  logic [NSLOT-1:0][W-1:0]       head_size;

  assign cfg_ready = 1'b1;

  always_comb begin
    sh_sat = cfg_data[BSL_W-1:0];
    if (sh_sat < BSL_MIN) begin
      sh_sat = BSL_MIN;
    end else if (sh_sat > BSL_MAX) begin
      sh_sat = BSL_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_mask <= (X'(1) << BSL_RESET) - X'(1);
      vol      <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BLOCK_SIZE_LOG2: blk_mask <= (X'(1) << sh_sat) - X'(1);
        CFG_VOLUME_SIZE:     vol      <= ADDR_BITS'(cfg_data);
        default:             blk_mask <= blk_mask;
      endcase
    end
  end

  rcds_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .blk_mask   (blk_mask),
    .vol        (vol),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .offset     (offset),
    .length     (length),
    .job_push   (job_push),
    .job_ready  (job_ready),
    .job_valid  (job_valid),
    .job_action (job_action),
    .job_start  (job_start),
    .job_size   (job_size)
  );

  assign q_din = {job_valid, job_action, job_start, job_size};

  rcds_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (job_push),
    .ready    (job_ready),
    .din      (q_din),
    .pop      (q_pop),
    .valid    (q_valid),
    .dout     (q_dout)
  );

  assign {head_valid, head_action, head_start, head_size} = q_dout;

  rcds_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .head_valid  (head_valid),
    .head_action (head_action),
    .head_start  (head_start),
    .head_size   (head_size),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .action      (action),
    .start_res   (start_res),
    .size        (size),
    .last        (last)
  );

endmodule

[test/range_coalesce_discard_split_checker.sv]
// Checker for the range coalescer: predicts device commands per record and compares them.
`timescale 1ns / 100ps

module rcds_checker #(
  parameter int AW = 48
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [rcds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcds_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [rcds_pkg::CMD_W-1:0]      command,
  input  logic [AW-1:0]                   offset,
  input  logic signed [AW-1:0]            length,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [rcds_pkg::ACT_W-1:0]      action,
  input  logic [AW:0]                     start_res,
  input  logic [AW:0]                     size,
  input  logic                            last,
  output int                              fail_count,
  output int                              due_count
);
  import rcds_pkg::*;

  typedef struct packed {
    act_t        act;
    logic [AW:0] start;
    logic [AW:0] size;
    logic        last;
  } dev_cmd_t;

  dev_cmd_t due_cmds[$];
  dev_cmd_t batch[$];

  logic [BSL_W-1:0]      blk_log2;
  logic [CFG_DATA_W-1:0] vol_bytes;
  logic                  pend_valid;
  logic [AW:0]           pend_start;
  logic [AW:0]           pend_end;

  task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
    $display("%0t: %s mismatch, expected %0h got %0h", $time, what, want, got);
    fail_count++;
  endtask

  function automatic void issue_cmd(input act_t act, input logic [63:0] st,
                                    input logic [63:0] sz);
    dev_cmd_t c;
    c.act   = act;
    c.start = st[AW:0];
    c.size  = sz[AW:0];
    c.last  = 1'b0;
    batch.insert(batch.size(), c);
  endfunction

  function automatic void release_pending();
    if (pend_valid) begin
      pend_valid = 1'b0;
      if (pend_end > pend_start)
        issue_cmd(ACT_COPY, 64'(pend_start), 64'(pend_end - pend_start));
    end
  endfunction

  function automatic void split_free(input logic [AW-1:0] off, input logic [AW-1:0] len);
    logic [63:0] vol, o, ln, bs, a, b, e;
    logic [BSL_W-1:0] sh;
    vol = 64'(vol_bytes[AW-1:0]);
    o   = 64'(off);
    sh  = (blk_log2 < BSL_MIN) ? BSL_MIN : ((blk_log2 > BSL_MAX) ? BSL_MAX : blk_log2);
    bs  = 64'd1 << sh;
    if (len[AW-1] || (o + 64'(len) > vol)) begin
      if (o >= vol) return;
      ln = vol - o;
    end else begin
      ln = 64'(len);
    end
    if (ln == 0) return;
    e = o + ln;
    a = (o + bs - 64'd1) & ~(bs - 64'd1);
    b = e & ~(bs - 64'd1);
    if (a < b) begin
      issue_cmd(ACT_DISCARD, a, b - a);
      if (a > o) issue_cmd(ACT_ZERO, o, a - o);
      if (e > b) issue_cmd(ACT_ZERO, b, e - b);
    end else begin
      issue_cmd(ACT_ZERO, o, ln);
    end
  endfunction

  function automatic void coalesce_record(input logic [CMD_W-1:0] cmd,
                                          input logic [AW-1:0] off,
                                          input logic [AW-1:0] len);
    logic [AW:0] wlen, wend;
    batch.delete();
    case (cmd)
      CMD_WRITE: begin
        wlen = len[AW-1] ? '0 : {1'b0, len};
        wend = {1'b0, off} + wlen;
        if (pend_valid && pend_end == {1'b0, off}) begin
          pend_end = wend;
        end else begin
          release_pending();
          pend_start = {1'b0, off};
          pend_end   = wend;
          pend_valid = 1'b1;
        end
      end
      CMD_FREE: begin
        release_pending();
        split_free(off, len);
      end
      CMD_FLUSH: release_pending();
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) due_cmds.insert(due_cmds.size(), batch[i]);
  endfunction

  always @(posedge clk) begin
    dev_cmd_t want;
    if (rst) begin
      blk_log2   = BSL_RESET;
      vol_bytes  = '0;
      pend_valid = 1'b0;
      pend_start = '0;
      pend_end   = '0;
      due_cmds.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BLOCK_SIZE_LOG2) blk_log2 = cfg_data[BSL_W-1:0];
        else if (cfg_index == CFG_VOLUME_SIZE) vol_bytes = cfg_data;
      end
      if (in_valid && in_ready) coalesce_record(command, offset, length);
      if (out_valid && out_ready) begin
        if (due_cmds.size() == 0) begin
          report("unexpected command", '0, 64'(start_res));
        end else begin
          want = due_cmds.pop_front();
          if (action !== want.act) report("action", 64'(want.act), 64'(action));
          if (start_res !== want.start) report("start_res", 64'(want.start), 64'(start_res));
          if (size !== want.size) report("size", 64'(want.size), 64'(size));
          if (last !== want.last) report("last", 64'(want.last), 64'(last));
        end
      end
    end
    due_count <= due_cmds.size();
  end

endmodule

[test/tb_range_coalesce_discard_split.sv]
// Testbench top for the range coalescer: drives records and config, gives the verdict.
`timescale 1ns / 100ps

module tb_range_coalesce_discard_split;
  import rcds_pkg::*;

  localparam int AW = 48;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [CMD_W-1:0]     CMD_RESERVED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [CMD_W-1:0]      command;
  logic [AW-1:0]         offset;
  logic signed [AW-1:0]  length;
  logic                  out_valid;
  logic                  out_ready;
  logic [ACT_W-1:0]      action;
  logic [AW:0]           start_res;
  logic [AW:0]           size;
  logic                  last;
  int                    fail_count;
  int                    due_count;

  bit          in_idle;
  bit          out_idle;
  int          cur_bs;
  logic [63:0] cur_vol;
  logic [63:0] run_end;
  bit          run_ok;
  int          quiet;

  range_coalesce_discard_split #(.ADDR_BITS(AW)) dut (.*);
  rcds_checker #(.AW(AW)) checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [63:0] rnd_bits(input int n);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r >> (64 - n);
  endfunction

  function automatic logic [AW-1:0] pick_offset();
    logic [63:0] r, pos;
    int span;
    r = {$urandom, $urandom};
    span = cur_bs * 4;
    case ($urandom_range(0, 7))
      0: pos = r;
      1: pos = (cur_vol > 64'(span)) ? cur_vol - 64'($urandom_range(0, span)) : 64'd0;
      2: pos = (r % (cur_vol + 64'd1)) & ~64'(cur_bs - 1);
      default: pos = r % (cur_vol + 64'd1);
    endcase
    return pos[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] pick_length();
    logic [63:0] len;
    case ($urandom_range(0, 9))
      0: len = {$urandom, $urandom};
      1: len = 64'd0;
      2: len = 64'd0 - 64'($urandom_range(1, 1000));
      3, 4, 5: len = 64'($urandom_range(1, 3 * cur_bs));
      default: begin
        len = 64'(cur_bs) * 64'($urandom_range(1, 8));
        if ($urandom_range(0, 1) != 0) len = len + 64'($urandom_range(0, cur_bs - 1));
      end
    endcase
    return len[AW-1:0];
  endfunction

  task automatic push_record(input logic [CMD_W-1:0] cmd, input logic [AW-1:0] off,
                             input logic [AW-1:0] len);
    int gap;
    gap = (in_idle && $urandom_range(0, 99) >= 60) ? stall_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    offset   <= off;
    length   <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [BSL_W-1:0] bsl, input logic [63:0] vol,
                            input bit spare);
    logic [63:0] junk;
    logic [BSL_W-1:0] eff;
    junk = {$urandom, $urandom};
    cfg_write(CFG_BLOCK_SIZE_LOG2, {junk[CFG_DATA_W-1:BSL_W], bsl});
    cfg_write(CFG_VOLUME_SIZE, vol[CFG_DATA_W-1:0]);
    if (spare) cfg_write(CFG_SPARE, junk[CFG_DATA_W-1:0]);
    cfg_valid <= 1'b0;
    eff = (bsl < BSL_MIN) ? BSL_MIN : ((bsl > BSL_MAX) ? BSL_MAX : bsl);
    cur_bs  = 1 << eff;
    cur_vol = 64'(vol[CFG_DATA_W-1:0]);
  endtask

  // wait for all commands, then for records that make none to clear the pipe
  task automatic settle();
    in_valid <= 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic random_record(output bit counted);
    logic [63:0] r, off, len;
    int pick;
    r = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    counted = 1'b1;
    if (pick < 45) begin
      off = (run_ok && $urandom_range(0, 3) != 0) ? run_end : 64'(pick_offset());
      len = 64'(pick_length());
      push_record(CMD_WRITE, off[AW-1:0], len[AW-1:0]);
      run_end = off + (len[AW-1] ? 64'd0 : len);
      run_ok  = (run_end[63:AW] == 0);
    end else if (pick < 80) begin
      push_record(CMD_FREE, pick_offset(), pick_length());
      run_ok = 1'b0;
    end else if (pick < 95) begin
      push_record(CMD_FLUSH, r[AW-1:0], r[63:64-AW]);
      run_ok = 1'b0;
    end else begin
      push_record(CMD_RESERVED, r[AW-1:0], r[63:64-AW]);
      counted = 1'b0;
    end
  endtask

  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (out_idle && $urandom_range(0, 99) < 25) begin
        out_ready <= 1'b0;
        repeat (stall_len()) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("no progress for %0d cycles", QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int n;
    bit counted;
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    command   = '0;
    offset    = '0;
    length    = '0;
    in_idle   = 1'b1;
    out_idle  = 1'b1;
    cur_bs    = 1 << BSL_RESET;
    cur_vol   = '0;
    run_end   = '0;
    run_ok    = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values: volume 0, block 4 KiB
    push_record(CMD_FLUSH, 48'h0, 48'h0);
    push_record(CMD_RESERVED, 48'hA5A5_1234_5678, 48'h5A5A_8765_4321);
    push_record(CMD_WRITE, 48'h1000, 48'h200);
    push_record(CMD_WRITE, 48'h1200, 48'h300);
    push_record(CMD_WRITE, 48'h1500, 48'hFFFF_FFFF_FFFB);
    push_record(CMD_WRITE, 48'h9000, 48'h0);
    push_record(CMD_FLUSH, 48'h0, 48'h0);
    push_record(CMD_FREE, 48'h0, 48'h100);
    push_record(CMD_WRITE, 48'hFFFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF);
    push_record(CMD_FLUSH, 48'h0, 48'h0);

    settle();
    set_config(5'd0, 64'd0, 1'b1);
    push_record(CMD_FREE, 48'h0, 48'hFFFF_FFFF_FFFF);
    push_record(CMD_WRITE, 48'h5, 48'h7);
    push_record(CMD_FREE, 48'h0, 48'h100);

    settle();
    set_config(BSL_MIN, 64'h10_0345, 1'b0);
    push_record(CMD_WRITE, 48'h10, 48'h20);
    push_record(CMD_FREE, 48'h1000, 48'h1000);
    push_record(CMD_FREE, 48'h100, 48'h1000);
    push_record(CMD_FREE, 48'h10, 48'h20);
    push_record(CMD_FREE, 48'h8_0000, 48'hFFFF_FFFF_FFFF);
    push_record(CMD_FREE, 48'h10_0345, 48'h5);
    push_record(CMD_FREE, 48'h1000, 48'h7FFF_FFFF_FFFF);
    push_record(CMD_FREE, 48'hFFFF_FFFF_FFFF, 48'h1);
    push_record(CMD_WRITE, 48'h20, 48'h10);
    push_record(CMD_FREE, 48'h300, 48'h1000);

    settle();
    set_config(5'd31, 64'hFFFF_FFFF_FFFF, 1'b0);
    push_record(CMD_FREE, 48'h0, 48'h8000_0000_0000);
    push_record(CMD_FREE, 48'h1_0000_0001, 48'h2_0000);
    push_record(CMD_FREE, 48'h2_0000, 48'h4_0000);
    push_record(CMD_WRITE, 48'hFFFF_FFFF_FFFF, 48'h0);
    push_record(CMD_FLUSH, 48'h0, 48'h0);

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      in_idle  = !ph[0];
      out_idle = !ph[1];
      case (ph)
        0: set_config(BSL_MIN, 64'h10_0000 + rnd_bits(16), 1'b0);
        1: set_config(BSL_MAX, (64'd1 << 39) | rnd_bits(40), 1'b0);
        2: set_config(BSL_W'($urandom_range(0, 31)), 64'hFFFF_FFFF_FFFF - rnd_bits(20), 1'b1);
        default: set_config(BSL_W'($urandom_range(10, 16)), (64'd1 << 23) | rnd_bits(23), 1'b0);
      endcase
      run_ok = 1'b0;
      n = 0;
      while (n < 84) begin
        random_record(counted);
        if (counted) n++;
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[range_coalesce_discard_split.f]
+incdir+rtl
rtl/rcds_pkg.sv
rtl/rcds_front.sv
rtl/rcds_queue.sv
rtl/rcds_back.sv
rtl/range_coalesce_discard_split.sv
test/range_coalesce_discard_split_checker.sv
test/tb_range_coalesce_discard_split.sv
